FILE: sv/tksl_pkg.sv
// Shared types and codes for the top-k sorted list with group dedup.
// Used by tksl_cell and top_k_sorted_list_with_group_dedup; depends on nothing.
`timescale 1ns / 1ps

package tksl_pkg;

  localparam int ID_W    = 32;
  localparam int GRP_W   = 16;
  localparam int SCORE_W = 32;
  localparam int LIMIT_W = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic [GRP_W-1:0]          grp;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_CAPTURE = 2'd1,
    CELL_INSERT  = 2'd2,
    CELL_ROTATE  = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       rm_valid;
  } cell_ctrl_t;

  // Per-cell compare results, captured when an insert command is taken.
  typedef struct packed {
    logic hit;        // valid entry of the same nonzero group
    logic hit_higher; // that entry scores strictly higher than the new item
    logic ins_at;     // new item goes at or before this cell (or cell is empty)
    logic below;      // new score is below this entry's score (or cell is empty)
  } cell_flags_t;

endpackage

FILE: sv/tksl_cell.sv
// One list position: holds an entry, compares it against the offered item,
// and shifts toward either neighbor. Depends on tksl_pkg.
`timescale 1ns / 1ps

module tksl_cell #(
  parameter int CAPACITY = 16,
  parameter int IDX = 0,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  tksl_pkg::cell_ctrl_t ctrl,
  input  tksl_pkg::entry_t     key,
  input  logic [CW-1:0]        count,
  input  logic [IW-1:0]        rm_idx,
  input  logic                 prev_ins_at,
  input  logic                 next_ins_at,
  input  tksl_pkg::entry_t     prev_entry,
  input  tksl_pkg::entry_t     next_entry,
  input  tksl_pkg::entry_t     head_entry,
  output tksl_pkg::entry_t     entry,
  output tksl_pkg::cell_flags_t flags
);

  localparam logic [CW-1:0] POS_C = CW'(IDX);
  localparam logic [CW-1:0] POS_N = CW'(IDX + 1);
  localparam logic [IW-1:0] POS_I = IW'(IDX);

  logic                                 valid;
  logic signed [tksl_pkg::SCORE_W-1:0]  own_score;
  logic signed [tksl_pkg::SCORE_W-1:0]  key_score;
  tksl_pkg::cell_flags_t                flags_next;
  tksl_pkg::entry_t                     ins_next;
  tksl_pkg::entry_t                     rot_next;
  logic                                 ge_rm;
  logic                                 gt_rm;

  assign valid     = POS_C < count;
  assign own_score = entry.score;
  assign key_score = key.score;

  always_comb begin
    flags_next.hit        = valid && (key.grp != '0) && (entry.grp == key.grp);
    flags_next.hit_higher = own_score > key_score;
    flags_next.ins_at     = !valid || (key_score > own_score);
    flags_next.below      = !valid || (key_score < own_score);
  end

  assign ge_rm = ctrl.rm_valid && (POS_I >= rm_idx);
  assign gt_rm = ctrl.rm_valid && (POS_I > rm_idx);

  // Removal and insertion in one step: cells between the removed slot and the
  // insert point move one place toward the gap, and the cell at the insert
  // point takes the new entry.
  always_comb begin
    ins_next = entry;
    if (flags.ins_at) begin
      if (!gt_rm) begin
        ins_next = prev_ins_at ? prev_entry : key;
      end
    end else if (ge_rm) begin
      ins_next = next_ins_at ? key : next_entry;
    end
  end

  // Read-out rotates the occupied cells by one place, head wrapping to the tail.
  always_comb begin
    rot_next = entry;
    if (POS_N < count) begin
      rot_next = next_entry;
    end else if (POS_N == count) begin
      rot_next = head_entry;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      tksl_pkg::CELL_CAPTURE: flags <= flags_next;
      tksl_pkg::CELL_INSERT:  entry <= ins_next;
      tksl_pkg::CELL_ROTATE:  entry <= rot_next;
      default: ;
    endcase
  end

endmodule

FILE: sv/top_k_sorted_list_with_group_dedup.sv
// Top level of the top-k sorted list with per-group dedup: control, decision
// logic and a chain of tksl_cell list positions. Depends on tksl_pkg, tksl_cell.
//
//   channel   | ports                                         | transfer when
//   ----------+-----------------------------------------------+----------------------
//   command   | start, busy, opcode, item_id, group_id, score | start && !busy
//   result    | result_strobe, accepted, entry_valid,         | result_strobe
//             | out_item_id, out_group_id, out_score, last    |
//   config    | cfg_we, cfg_wdata (entry_limit)               | cfg_we
//
// Insert: every cell compares at the command transfer, ST_DEC reduces the cell
// flags into a decision, and ST_UPD shifts the cells.
// Read-out rotates the chain once per entry, with one result for each entry;
// clear and an empty read-out answer straight from idle; opcode 3 gives no result.
// Synchronous active-high reset empties the list and sets the limit to 16.
// Results cannot be stalled; each one is valid for the single strobe cycle.
`timescale 1ns / 1ps

module top_k_sorted_list_with_group_dedup #(
  parameter int CAPACITY   = 16,
  parameter int GROUP_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           opcode,
  input  logic [tksl_pkg::ID_W-1:0]            item_id,
  input  logic [tksl_pkg::GRP_W-1:0]           group_id,
  input  logic signed [tksl_pkg::SCORE_W-1:0]  score,
  input  logic                                 cfg_we,
  input  logic [tksl_pkg::LIMIT_W-1:0]         cfg_wdata,
  output logic                                 result_strobe,
  output logic                                 accepted,
  output logic                                 entry_valid,
  output logic [tksl_pkg::ID_W-1:0]            out_item_id,
  output logic [tksl_pkg::GRP_W-1:0]           out_group_id,
  output logic signed [tksl_pkg::SCORE_W-1:0]  out_score,
  output logic                                 last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int LW = (CW > tksl_pkg::LIMIT_W) ? CW : tksl_pkg::LIMIT_W;
  localparam logic [tksl_pkg::GRP_W-1:0] GRP_MASK =
    (GROUP_BITS >= tksl_pkg::GRP_W) ? {tksl_pkg::GRP_W{1'b1}} :
    tksl_pkg::GRP_W'((1 << GROUP_BITS) - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DEC  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_READ = 4'b1000
  } state_t;

  state_t                         state;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  rd_k;
  logic [tksl_pkg::LIMIT_W-1:0]   limit;
  tksl_pkg::entry_t               key_q;
  tksl_pkg::entry_t               key_in;
  tksl_pkg::entry_t               key;
  logic                           acc_q;
  logic                           rm_q;
  logic [IW-1:0]                  rm_idx;
  logic                           take;
  tksl_pkg::cell_ctrl_t           ctrl;

  tksl_pkg::entry_t               cell_entry [CAPACITY];
  tksl_pkg::cell_flags_t          cell_fl    [CAPACITY];

  logic                           any_hit;
  logic                           hit_ref;
  logic                           all_below;
  logic [IW-1:0]                  hit_idx;
  logic [LW-1:0]                  eff_lim;
  logic                           full;
  logic                           acc_d;
  logic                           rm_d;
  logic [IW-1:0]                  rm_idx_next;

  assign busy = (state != ST_IDLE);
  assign take = start && !busy;

  assign key_in.id    = item_id;
  assign key_in.grp   = group_id & GRP_MASK;
  assign key_in.score = score;
  assign key = busy ? key_q : key_in;

  always_comb begin
    ctrl.rm_valid = rm_q;
    ctrl.mode     = tksl_pkg::CELL_HOLD;
    if (take && (opcode == tksl_pkg::OP_INSERT)) begin
      ctrl.mode = tksl_pkg::CELL_CAPTURE;
    end else if ((state == ST_UPD) && acc_q) begin
      ctrl.mode = tksl_pkg::CELL_INSERT;
    end else if (state == ST_READ) begin
      ctrl.mode = tksl_pkg::CELL_ROTATE;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    tksl_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key),
      .count       (count),
      .rm_idx      (rm_idx),
      .prev_ins_at ((g == 0) ? 1'b0 : cell_fl[(g == 0) ? 0 : g - 1].ins_at),
      .next_ins_at ((g == CAPACITY - 1) ? 1'b1
                    : cell_fl[(g == CAPACITY - 1) ? g : g + 1].ins_at),
      .prev_entry  (cell_entry[(g == 0) ? 0 : g - 1]),
      .next_entry  (cell_entry[(g == CAPACITY - 1) ? g : g + 1]),
      .head_entry  (cell_entry[0]),
      .entry       (cell_entry[g]),
      .flags       (cell_fl[g])
    );
  end

  // Effective limit: zero counts as one, anything above the capacity as the capacity.
  always_comb begin
    eff_lim = LW'(limit);
    if (limit == '0) begin
      eff_lim = LW'(1);
    end else if (LW'(limit) > LW'(CAPACITY)) begin
      eff_lim = LW'(CAPACITY);
    end
  end
  assign full = LW'(count) >= eff_lim;

  always_comb begin
    any_hit   = 1'b0;
    hit_ref   = 1'b0;
    all_below = 1'b1;
    hit_idx   = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      any_hit   = any_hit | cell_fl[j].hit;
      hit_ref   = hit_ref | (cell_fl[j].hit & cell_fl[j].hit_higher);
      all_below = all_below & cell_fl[j].below;
      hit_idx   = hit_idx | (cell_fl[j].hit ? IW'(j) : '0);
    end
  end

  // Scores are sorted, so the new score lies below every entry exactly when it
  // lies below the tail.
  assign acc_d       = !(full && (count != '0) && all_below) && !hit_ref;
  assign rm_d        = any_hit || (full && (count != '0));
  assign rm_idx_next = any_hit ? hit_idx : IW'(count - CW'(1));

  always_ff @(posedge clk) begin
    if (take) begin
      key_q <= key_in;
    end
    if (state == ST_DEC) begin
      acc_q  <= acc_d;
      rm_q   <= rm_d;
      rm_idx <= rm_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      rd_k          <= '0;
      limit         <= tksl_pkg::LIMIT_RESET;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            accepted     <= 1'b0;
            entry_valid  <= 1'b0;
            out_item_id  <= '0;
            out_group_id <= '0;
            out_score    <= '0;
            last         <= 1'b1;
            case (opcode)
              tksl_pkg::OP_INSERT: begin
                state <= ST_DEC;
              end
              tksl_pkg::OP_READ: begin
                if (count == '0) begin
                  result_strobe <= 1'b1;
                end else begin
                  rd_k  <= '0;
                  state <= ST_READ;
                end
              end
              tksl_pkg::OP_CLEAR: begin
                count         <= '0;
                result_strobe <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_DEC: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (acc_q && !rm_q) begin
            count <= count + CW'(1);
          end
          accepted      <= acc_q;
          result_strobe <= 1'b1;
          state         <= ST_IDLE;
        end
        ST_READ: begin
          result_strobe <= 1'b1;
          accepted      <= 1'b0;
          entry_valid   <= 1'b1;
          out_item_id   <= cell_entry[0].id;
          out_group_id  <= cell_entry[0].grp;
          out_score     <= cell_entry[0].score;
          last          <= (rd_k + CW'(1)) == count;
          rd_k          <= rd_k + CW'(1);
          if ((rd_k + CW'(1)) == count) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted insert without removal grows the list by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) && acc_q && !rm_q |=> count == $past(count) + CW'(1))
    else $error("count did not grow after an insert into free space");

  // The list never holds more entries than there are cells.
  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A removal always targets an occupied cell.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) && acc_q && rm_q |-> CW'(rm_idx) < count)
    else $error("removal index outside the occupied cells");

  // Every result follows a command transfer, a shift step or a read-out step.
  assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(take) || $past(state == ST_UPD) || $past(state == ST_READ))
    else $error("result strobe without a cause");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for top_k_sorted_list_with_group_dedup: directed and random
// commands, a built-in predictor of the sorted list, and a result checker.
// Depends on tksl_pkg and the top_k_sorted_list_with_group_dedup RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int LIST_DEPTH     = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    bit [31:0]        id;
    bit [15:0]        grp;
    bit signed [31:0] score;
  } slot_t;

  typedef struct {
    bit               accepted;
    bit               entry_valid;
    bit [31:0]        id;
    bit [15:0]        grp;
    bit signed [31:0] score;
    bit               last;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  opcode = tksl_pkg::OP_INSERT;
  logic [31:0] item_id = '0;
  logic [15:0] group_id = '0;
  logic signed [31:0] score = '0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        busy;
  logic        result_strobe;
  logic        accepted;
  logic        entry_valid;
  logic [31:0] out_item_id;
  logic [15:0] out_group_id;
  logic signed [31:0] out_score;
  logic        last;

  // Predicted list contents and limit register.
  slot_t       ranked [LIST_DEPTH];
  int unsigned ranked_count = 0;
  bit [4:0]    limit_reg = tksl_pkg::LIMIT_RESET;

  outcome_t    pending_results [$];
  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned commands_sent = 0;
  int unsigned inserts_taken = 0;
  int unsigned inserts_refused = 0;
  int unsigned readouts_sent = 0;
  int unsigned gap_pct = 0;
  int unsigned idle_cycles = 0;

  top_k_sorted_list_with_group_dedup dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .item_id      (item_id),
    .group_id     (group_id),
    .score        (score),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_strobe(result_strobe),
    .accepted     (accepted),
    .entry_valid  (entry_valid),
    .out_item_id  (out_item_id),
    .out_group_id (out_group_id),
    .out_score    (out_score),
    .last         (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void rank_remove(int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < ranked_count; i++) ranked[i] = ranked[i + 1];
    ranked_count--;
  endfunction

  function automatic bit rank_insert(bit [31:0] id, bit [15:0] grp, bit signed [31:0] sc);
    int unsigned lim;
    int unsigned pos;
    int unsigned i;
    bit full;
    lim = 32'(limit_reg);
    if (lim == 0) lim = 1;
    if (lim > LIST_DEPTH) lim = LIST_DEPTH;
    full = ranked_count >= lim;
    if (full && ranked_count > 0 && sc < ranked[ranked_count - 1].score) return 1'b0;
    if (grp != 0) begin
      for (i = 0; i < ranked_count; i++) begin
        if (ranked[i].grp == grp) begin
          if (ranked[i].score > sc) return 1'b0;
          rank_remove(i);
          full = 1'b0;
          break;
        end
      end
    end
    if (full && ranked_count > 0) rank_remove(ranked_count - 1);
    if (ranked_count >= LIST_DEPTH) return 1'b0;
    // Ties keep their order: the newcomer lands after every equal score.
    pos = 0;
    while (pos < ranked_count && !(sc > ranked[pos].score)) pos++;
    for (i = ranked_count; i > pos; i--) ranked[i] = ranked[i - 1];
    ranked[pos] = '{id, grp, sc};
    ranked_count++;
    return 1'b1;
  endfunction

  function automatic void predict_command(tksl_pkg::opcode_t op, bit [31:0] id,
                                          bit [15:0] grp, bit signed [31:0] sc);
    outcome_t r;
    int unsigned k;
    r = '{default: '0};
    r.last = 1'b1;
    case (op)
      tksl_pkg::OP_INSERT: begin
        r.accepted = rank_insert(id, grp, sc);
        if (r.accepted) inserts_taken++;
        else inserts_refused++;
        pending_results.push_back(r);
      end
      tksl_pkg::OP_CLEAR: begin
        ranked_count = 0;
        pending_results.push_back(r);
      end
      tksl_pkg::OP_READ: begin
        readouts_sent++;
        if (ranked_count == 0) pending_results.push_back(r);
        for (k = 0; k < ranked_count; k++) begin
          r.entry_valid = 1'b1;
          r.id = ranked[k].id;
          r.grp = ranked[k].grp;
          r.score = ranked[k].score;
          r.last = (k + 1 == ranked_count);
          pending_results.push_back(r);
        end
      end
      default: ; // the unused opcode is dropped by the block
    endcase
  endfunction

  // Drives one command and waits for its transfer; start stays high unless a gap follows.
  task automatic issue(tksl_pkg::opcode_t op, bit [31:0] id, bit [15:0] grp,
                       bit [31:0] sc);
    start    <= 1'b1;
    opcode   <= op;
    item_id  <= id;
    group_id <= grp;
    score    <= sc;
    do @(posedge clk); while (busy);
    predict_command(op, id, grp, $signed(sc));
    if (op != tksl_pkg::OP_NONE) commands_sent++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Quiet clocks separate the drained block from whatever follows.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(bit [4:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    limit_reg = value;
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && result_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got id %0h group %0h score %0h",
                 $time, out_item_id, out_group_id, out_score);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(accepted));
        check_field("entry_valid", 32'(want.entry_valid), 32'(entry_valid));
        check_field("out_item_id", want.id, out_item_id);
        check_field("out_group_id", 32'(want.grp), 32'(out_group_id));
        check_field("out_score", want.score, out_score);
        check_field("last", 32'(want.last), 32'(last));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic test_basic_ops();
    issue(tksl_pkg::OP_READ, 32'h0, 16'h0, 32'h0);
    issue(tksl_pkg::OP_CLEAR, 32'h0, 16'h0, 32'h0);
    issue(tksl_pkg::OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    issue(tksl_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h0000, 32'h7FFF_FFFF);
    issue(tksl_pkg::OP_INSERT, 32'h0000_0000, 16'hFFFF, 32'h8000_0000);
    issue(tksl_pkg::OP_INSERT, 32'h0000_0001, 16'h0000, 32'h0000_0000);
    issue(tksl_pkg::OP_INSERT, 32'h0000_0002, 16'h0000, 32'h0000_0000);
    issue(tksl_pkg::OP_READ, 32'h0, 16'h0, 32'h0);
  endtask

  task automatic test_group_dedup();
    issue(tksl_pkg::OP_CLEAR, 32'h0, 16'h0, 32'h0);
    issue(tksl_pkg::OP_INSERT, 32'h10, 16'h5, 32'h0064_0000);
    issue(tksl_pkg::OP_INSERT, 32'h11, 16'h5, 32'h0032_0000);  // group holds a higher score
    issue(tksl_pkg::OP_INSERT, 32'h12, 16'h5, 32'h0064_0000);  // equal score replaces older
    // The group's entry is the only one; it is removed and the list refilled from empty.
    issue(tksl_pkg::OP_INSERT, 32'h13, 16'h5, 32'h00C8_0000);
    issue(tksl_pkg::OP_READ, 32'h0, 16'h0, 32'h0);
  endtask

  task automatic test_limit_edges();
    write_limit(5'd2);
    issue(tksl_pkg::OP_CLEAR, 32'h0, 16'h0, 32'h0);
    issue(tksl_pkg::OP_INSERT, 32'h20, 16'h0, 32'h000A_0000);
    issue(tksl_pkg::OP_INSERT, 32'h21, 16'h0, 32'h0014_0000);
    issue(tksl_pkg::OP_INSERT, 32'h22, 16'h0, 32'h0005_0000);  // full and below the tail
    issue(tksl_pkg::OP_INSERT, 32'h23, 16'h0, 32'h000A_0000);  // ties the tail, which is evicted
    issue(tksl_pkg::OP_READ, 32'h0, 16'h0, 32'h0);
    // A zero limit acts as one, now below the number of entries held.
    write_limit(5'd0);
    issue(tksl_pkg::OP_INSERT, 32'h24, 16'h0, 32'h0001_0000);
    issue(tksl_pkg::OP_INSERT, 32'h25, 16'h0, 32'h001E_0000);
    issue(tksl_pkg::OP_READ, 32'h0, 16'h0, 32'h0);
    write_limit(5'd31);
    issue(tksl_pkg::OP_INSERT, 32'h26, 16'h7, 32'hFFFF_0000);
    issue(tksl_pkg::OP_READ, 32'h0, 16'h0, 32'h0);
  endtask

  task automatic random_command();
    int unsigned pick;
    bit [15:0] grp;
    bit [31:0] sc;
    tksl_pkg::opcode_t op;
    pick = $urandom_range(99);
    if (pick < 76) op = tksl_pkg::OP_INSERT;
    else if (pick < 89) op = tksl_pkg::OP_READ;
    else if (pick < 94) op = tksl_pkg::OP_CLEAR;
    else op = tksl_pkg::OP_NONE;
    // A few groups and a few tied scores keep dedup and tie ordering busy.
    pick = $urandom_range(9);
    if (pick < 6) grp = 16'($urandom_range(1, 6));
    else if (pick < 8) grp = 16'h0;
    else grp = 16'($urandom_range(0, 16'hFFFF));
    pick = $urandom_range(9);
    if (pick < 4) sc = ($urandom_range(0, 6) - 3) << 16;
    else if (pick < 8) sc = $urandom;
    else if (pick == 8) sc = 32'h7FFF_FFFF;
    else sc = 32'h8000_0000;
    issue(op, $urandom, grp, sc);
  endtask

  task automatic test_random_traffic();
    // The result side cannot be stalled, so only the command side idles.
    int unsigned phase_pct [4] = '{0, 50, 0, 7};
    int unsigned target;
    int unsigned phase;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_limit(5'd16);
        1: write_limit(5'($urandom_range(1, 16)));
        2: write_limit(5'd3);
        default: write_limit(5'd1);
      endcase
      gap_pct = phase_pct[phase];
      target = commands_sent + 40;
      while (commands_sent < target) begin
        random_command();
        if ($urandom_range(29) == 0) wait_drained();
      end
    end
    gap_pct = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_group_dedup();
    test_limit_edges();
    test_random_traffic();
    wait_drained();
    repeat (24) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results still outstanding, expected 0", $time,
               pending_results.size());
      error_count++;
    end
    $display("Covered %0d commands: %0d inserts taken, %0d refused, %0d read-outs.",
             commands_sent, inserts_taken, inserts_refused, readouts_sent);
    $display("Checked %0d results across list limits 0, 1, 2, 3, 16 and 31.",
             results_checked);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
